// File: rtl/pqu_pkg.sv
// shared types and constants of the prime query unit
`default_nettype none
package pqu_pkg;
    localparam int OperandWidth = 16;
    localparam int ValueWidth   = 16;
    localparam int NeighborWidth = OperandWidth + 2;
    localparam int CountWidth   = $clog2(NeighborWidth + 1);

    typedef enum logic [2:0] {
        OP_DIVISIBLE    = 3'd0,
        OP_IS_PRIME     = 3'd1,
        OP_NEXT_PRIME   = 3'd2,
        OP_COUNT_PRIMES = 3'd3,
        OP_IS_TWIN      = 3'd4,
        OP_NEXT_TWIN    = 3'd5,
        OP_LARGEST_TWIN = 3'd6,
        OP_UNUSED       = 3'd7
    } t_opcode;

    // request to the bit-serial remainder unit
    typedef struct packed {
        logic                     start;
        logic [NeighborWidth-1:0] dividend;
        logic [NeighborWidth-1:0] divisor;
    } t_div_req;

    // answer from the remainder unit
    typedef struct packed {
        logic                     done;
        logic                     zero_rem;
        logic                     sq_above;
    } t_div_rsp;
endpackage
`default_nettype wire

// File: rtl/pqu_divider.sv
// restoring divider, one quotient bit per cycle, also reports d*d > n
`default_nettype none
module pqu_divider (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire pqu_pkg::t_div_req i_req,
    output pqu_pkg::t_div_rsp  o_rsp
);
    import pqu_pkg::*;

    logic                     r_busy, n_busy;
    logic [NeighborWidth-1:0] r_rem, n_rem;
    logic [NeighborWidth-1:0] r_quo, n_quo;
    logic [NeighborWidth-1:0] r_div, n_div;
    logic [CountWidth-1:0]    r_cnt, n_cnt;
    logic                     r_done, n_done;
    logic [NeighborWidth:0]   w_trial;
    logic [NeighborWidth-1:0] w_final_rem;

    // one shift-subtract step per cycle
    always_comb begin
        n_busy = r_busy;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[NeighborWidth-1]} - {1'b0, r_div};
        w_final_rem = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
            n_cnt  = CountWidth'(NeighborWidth);
        end else if (r_busy) begin
            n_quo = {r_quo[NeighborWidth-2:0], ~w_trial[NeighborWidth]};
            if (w_trial[NeighborWidth]) begin
                n_rem = {r_rem[NeighborWidth-2:0], r_quo[NeighborWidth-1]};
            end else begin
                n_rem = w_trial[NeighborWidth-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CountWidth'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    // d*d > n  is  quotient < d
    assign o_rsp.done     = r_done;
    assign o_rsp.zero_rem = (w_final_rem == '0);
    assign o_rsp.sq_above = (r_quo < r_div);
endmodule
`default_nettype wire

// File: rtl/pqu_prime_test.sv
// trial-division primality test, or a single divisibility check, over the shared divider
`default_nettype none
module pqu_prime_test (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire                                 i_mod_only,
    input  wire [pqu_pkg::NeighborWidth-1:0]    i_n,
    input  wire [pqu_pkg::NeighborWidth-1:0]    i_d,
    output logic                                o_done,
    output logic                                o_result
);
    import pqu_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WAIT, S_FIN} t_state;

    t_state                   r_state;
    logic [NeighborWidth-1:0] r_n;
    logic [NeighborWidth-1:0] r_d;
    logic                     r_mod;
    logic                     r_res;
    logic                     r_go;
    t_div_req                 w_req;
    t_div_rsp                 w_rsp;

    assign w_req.start    = r_go;
    assign w_req.dividend = r_n;
    assign w_req.divisor  = r_d;

    pqu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // sweep divisors from 2 until d*d > n or one divides; mod-only mode tests the given divisor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_go   <= 1'b0;
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n   <= i_n;
                        r_mod <= i_mod_only;
                        if (i_mod_only) begin
                            r_d <= i_d;
                            if (i_d == '0) begin
                                r_res   <= 1'b0;
                                r_state <= S_FIN;
                            end else begin
                                r_go    <= 1'b1;
                                r_state <= S_WAIT;
                            end
                        end else if (i_n < NeighborWidth'(2)) begin
                            r_res   <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_d     <= NeighborWidth'(2);
                            r_go    <= 1'b1;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_mod) begin
                            r_res   <= w_rsp.zero_rem;
                            r_state <= S_FIN;
                        end else if (w_rsp.sq_above) begin
                            r_res   <= 1'b1;
                            r_state <= S_FIN;
                        end else if (w_rsp.zero_rem) begin
                            r_res   <= 1'b0;
                            r_state <= S_FIN;
                        end else begin
                            r_d  <= r_d + 1'b1;
                            r_go <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result = r_res;
endmodule
`default_nettype wire

// File: rtl/prime_query_unit.sv
// top level: request sequencer of the prime query unit
// a divisible query runs one division; a primality test runs one division per trial
//   divisor from 2 until d*d > n, on the bit-serial divider
// searches and range sweeps test candidates in turn, twins with up to three primality tests each
// throughput: one request at a time; the next is taken once the result word leaves
// reset: synchronous active low, clears the sequencer and output valid
`default_nettype none
module prime_query_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], first_value[18:3], second_value[34:19], zero fill to 40
    input  wire  [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // value[15:0], truth[16], none_found[17], overflow[18], zero fill to 24
    output logic [23:0] m_axis_tdata
);
    import pqu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_T1, S_W1, S_T2, S_W2, S_T3, S_W3, S_NEXT, S_OUT
    } t_state;

    localparam logic [NeighborWidth-1:0] Top = NeighborWidth'((1 << OperandWidth) - 1);

    t_state                   r_state;
    t_opcode                  r_op;
    logic [NeighborWidth-1:0] r_a, r_b, r_c;
    logic [ValueWidth-1:0]    r_value;
    logic                     r_truth, r_none, r_ovf;
    logic                     r_pstart, r_pmod;
    logic [NeighborWidth-1:0] r_pn;
    logic                     w_pdone, w_pres;
    logic                     w_twin_op;

    pqu_prime_test u_prime (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_pstart),
        .i_mod_only (r_pmod),
        .i_n        (r_pn),
        .i_d        (r_b),
        .o_done     (w_pdone),
        .o_result   (w_pres)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_ovf, r_none, r_truth, r_value};
    assign w_twin_op = (r_op == OP_IS_TWIN) || (r_op == OP_NEXT_TWIN)
                    || (r_op == OP_LARGEST_TWIN);

    // sequencer: candidate c tested as prime (or for divisibility), then c-2 and, if c-2 is not prime, c+2 for twins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pstart <= 1'b0;
        end else begin
            r_pstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= t_opcode'(s_axis_tdata[2:0]);
                        r_a     <= NeighborWidth'(s_axis_tdata[18:3]);
                        r_b     <= NeighborWidth'(s_axis_tdata[34:19]);
                        r_value <= '0;
                        r_truth <= 1'b0;
                        r_none  <= 1'b0;
                        r_ovf   <= 1'b0;
                        unique case (t_opcode'(s_axis_tdata[2:0]))
                            OP_DIVISIBLE, OP_IS_PRIME, OP_IS_TWIN: begin
                                r_c     <= NeighborWidth'(s_axis_tdata[18:3]);
                                r_state <= S_T1;
                            end
                            OP_NEXT_PRIME, OP_NEXT_TWIN: begin
                                r_c     <= NeighborWidth'(s_axis_tdata[18:3]) + 1'b1;
                                r_state <= S_NEXT;
                            end
                            OP_COUNT_PRIMES: begin
                                r_c <= NeighborWidth'(s_axis_tdata[18:3]);
                                r_state <= (s_axis_tdata[18:3] > s_axis_tdata[34:19])
                                         ? S_OUT : S_T1;
                            end
                            OP_LARGEST_TWIN: begin
                                r_c    <= NeighborWidth'(s_axis_tdata[34:19]);
                                r_none <= 1'b1;
                                r_state <= (s_axis_tdata[18:3] > s_axis_tdata[34:19])
                                         ? S_OUT : S_T1;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                // bound check for next searches
                S_NEXT: begin
                    if (r_c > Top) begin
                        r_ovf   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_T1;
                    end
                end
                S_T1: begin
                    r_pn     <= r_c;
                    r_pmod   <= (r_op == OP_DIVISIBLE);
                    r_pstart <= 1'b1;
                    r_state  <= S_W1;
                end
                S_W1: begin
                    if (w_pdone) begin
                        if (w_twin_op && w_pres && r_c > NeighborWidth'(2)) begin
                            r_state <= S_T2;
                        end else begin
                            r_state <= S_T3;
                        end
                    end
                end
                S_T2: begin
                    r_pn     <= r_c - NeighborWidth'(2);
                    r_pmod   <= 1'b0;
                    r_pstart <= 1'b1;
                    r_state  <= S_W2;
                end
                S_W2: begin
                    if (w_pdone) begin
                        if (w_pres) begin
                            r_state <= S_W3;
                            r_pn    <= '0;
                        end else begin
                            r_pn     <= r_c + NeighborWidth'(2);
                            r_pstart <= 1'b1;
                            r_state  <= S_W3;
                        end
                    end
                end
                // S_W3 waits on the c+2 test, or decides at once when c-2 was prime
                S_W3: begin
                    if (r_pn == '0 || w_pdone) begin
                        if (r_pn == '0 || w_pres) begin
                            // twin found
                            unique case (r_op)
                                OP_IS_TWIN: begin
                                    r_truth <= 1'b1;
                                    r_state <= S_OUT;
                                end
                                OP_NEXT_TWIN, OP_LARGEST_TWIN: begin
                                    r_value <= ValueWidth'(r_c);
                                    r_none  <= 1'b0;
                                    r_state <= S_OUT;
                                end
                                default: r_state <= S_OUT;
                            endcase
                        end else begin
                            r_state <= S_T3;
                        end
                    end
                end
                // S_T3 decides after a candidate
                S_T3: begin
                    unique case (r_op)
                        OP_DIVISIBLE, OP_IS_PRIME: begin
                            r_truth <= w_pres;
                            r_state <= S_OUT;
                        end
                        OP_IS_TWIN: r_state <= S_OUT;
                        OP_NEXT_PRIME: begin
                            if (w_pres) begin
                                r_value <= ValueWidth'(r_c);
                                r_state <= S_OUT;
                            end else begin
                                r_c     <= r_c + 1'b1;
                                r_state <= S_NEXT;
                            end
                        end
                        OP_NEXT_TWIN: begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_NEXT;
                        end
                        OP_COUNT_PRIMES: begin
                            if (w_pres) r_value <= r_value + 1'b1;
                            if (r_c == r_b) begin
                                r_state <= S_OUT;
                            end else begin
                                r_c     <= r_c + 1'b1;
                                r_state <= S_T1;
                            end
                        end
                        OP_LARGEST_TWIN: begin
                            if (r_c == r_a) begin
                                r_state <= S_OUT;
                            end else begin
                                r_c     <= r_c - 1'b1;
                                r_state <= S_T1;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result word stays put while it waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    // no request taken while a result is pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request accepted during pending result");
    // none_found only for the largest twin search
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_none |-> r_op == OP_LARGEST_TWIN)
        else $error("none_found on wrong operation");
endmodule
`default_nettype wire

// File: test/tb_prime_query_unit.sv
// testbench of the prime query unit: random and directed queries checked against a predictor
`timescale 1ns / 1ps
module tb_prime_query_unit;
    import pqu_pkg::*;

    localparam int OpMax    = (1 << OperandWidth) - 1;
    localparam int HoldLen  = 400;
    localparam int HoldAt   = 20;

    // expected result word of one query
    typedef struct packed {
        logic [15:0] value;
        logic        truth;
        logic        none_found;
        logic        overflow;
    } t_answer;

    // answer store and query predictor
    class query_scoreboard;
        t_answer pending[$];

        function bit is_prime(longint n);
            longint d;
            if (n < 2) return 0;
            for (d = 2; d * d <= n; d++)
                if (n % d == 0) return 0;
            return 1;
        endfunction

        function bit is_twin(longint n);
            if (n <= 2 || !is_prime(n)) return 0;
            return is_prime(n - 2) || is_prime(n + 2);
        endfunction

        // work out the answer of an accepted query
        function void note_query(t_opcode op, logic [15:0] a, logic [15:0] b);
            t_answer ans;
            longint c;
            ans = '0;
            case (op)
                OP_DIVISIBLE:  ans.truth = (b != 0) && (a % b == 0);
                OP_IS_PRIME:   ans.truth = is_prime(a);
                OP_IS_TWIN:    ans.truth = is_twin(a);
                OP_NEXT_PRIME, OP_NEXT_TWIN: begin
                    ans.overflow = 1;
                    for (c = longint'(a) + 1; c <= OpMax; c++) begin
                        if (op == OP_NEXT_PRIME ? is_prime(c) : is_twin(c)) begin
                            ans.value = c[15:0];
                            ans.overflow = 0;
                            break;
                        end
                    end
                end
                OP_COUNT_PRIMES: begin
                    for (c = longint'(a); c <= longint'(b); c++)
                        if (is_prime(c)) ans.value++;
                end
                OP_LARGEST_TWIN: begin
                    ans.none_found = 1;
                    for (c = longint'(b); c >= longint'(a); c--) begin
                        if (is_twin(c)) begin
                            ans.value = c[15:0];
                            ans.none_found = 0;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(ans);
        endfunction

        // compare a result word with the oldest answer; empty string when it matches
        function string check_result(logic [23:0] word);
            t_answer want;
            if (pending.size() == 0)
                return $sformatf("unexpected result word %h", word);
            want = pending.pop_front();
            if (word[15:0] !== want.value)
                return $sformatf("value %0d, expected %0d", word[15:0], want.value);
            if (word[16] !== want.truth)
                return $sformatf("truth %b, expected %b", word[16], want.truth);
            if (word[17] !== want.none_found)
                return $sformatf("none_found %b, expected %b", word[17], want.none_found);
            if (word[18] !== want.overflow)
                return $sformatf("overflow %b, expected %b", word[18], want.overflow);
            return "";
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    query_scoreboard sb;
    int          mismatches;
    int          results_seen;
    int          query_index;
    bit          calm_stretch;

    prime_query_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // send one query word and note it once accepted
    task automatic send_query(t_opcode op, logic [15:0] a, logic [15:0] b);
        while (!calm_stretch && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, b, a, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_query(op, a, b);
        query_index++;
    endtask

    // draw one random query, mostly small operands to keep trial division short
    task automatic send_random;
        t_opcode     op;
        logic [15:0] a;
        logic [15:0] b;
        op = t_opcode'($urandom_range(7));
        a = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
        b = 16'($urandom);
        if (op == OP_COUNT_PRIMES || op == OP_LARGEST_TWIN) begin
            if ($urandom_range(3) == 0)
                a = 16'($urandom);
            else
                a = 16'($urandom_range(1023));
            if ($urandom_range(7) == 0)
                b = (a == 0) ? 16'd0 : a - 16'($urandom_range(1, a < 5 ? a : 5));
            else
                b = (a > OpMax - 24) ? 16'(OpMax) : a + 16'($urandom_range(24));
        end
        send_query(op, a, b);
    endtask

    // result side: random stalls and one long hold-off
    initial begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && query_index >= HoldAt) begin
                held = 1;
                hold = HoldLen;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm_stretch || ($urandom_range(99) >= 20);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            msg = sb.check_result(m_axis_tdata);
            if (msg != "") report(msg);
            results_seen++;
        end
    end

    // stimulus and end of run
    initial begin
        int wait_cycles;
        sb = new();
        mismatches = 0;
        results_seen = 0;
        query_index = 0;
        calm_stretch = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corner operands of every operation
        send_query(OP_DIVISIBLE, 16'd12, 16'd0);
        send_query(OP_DIVISIBLE, 16'd0, 16'd7);
        send_query(OP_DIVISIBLE, 16'hFFFF, 16'hFFFF);
        send_query(OP_DIVISIBLE, 16'hFFFF, 16'd2);
        send_query(OP_IS_PRIME, 16'd0, 16'd0);
        send_query(OP_IS_PRIME, 16'd1, 16'd0);
        send_query(OP_IS_PRIME, 16'd2, 16'd0);
        send_query(OP_IS_PRIME, 16'd65521, 16'd0);
        send_query(OP_IS_PRIME, 16'hFFFF, 16'd0);
        send_query(OP_NEXT_PRIME, 16'd0, 16'd0);
        send_query(OP_NEXT_PRIME, 16'd65521, 16'd0);
        send_query(OP_COUNT_PRIMES, 16'd0, 16'd20);
        send_query(OP_COUNT_PRIMES, 16'd30, 16'd10);
        send_query(OP_COUNT_PRIMES, 16'hFFF0, 16'hFFFF);
        send_query(OP_IS_TWIN, 16'd2, 16'd0);
        send_query(OP_IS_TWIN, 16'd3, 16'd0);
        send_query(OP_IS_TWIN, 16'd65519, 16'd0);
        send_query(OP_IS_TWIN, 16'd65521, 16'd0);
        send_query(OP_NEXT_TWIN, 16'd0, 16'd0);
        send_query(OP_NEXT_TWIN, 16'd65500, 16'd0);
        send_query(OP_LARGEST_TWIN, 16'd0, 16'd10);
        send_query(OP_LARGEST_TWIN, 16'd24, 16'd28);
        send_query(OP_LARGEST_TWIN, 16'd9, 16'd3);
        send_query(OP_UNUSED, 16'hFFFF, 16'hFFFF);

        // random queries, with a stretch free of idling in the middle
        for (int i = 0; i < 116; i++) begin
            calm_stretch = (i >= 50 && i < 80);
            send_random();
        end
        calm_stretch = 0;
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20000000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #200000000;
        $display("status: fail");
        $finish;
    end
endmodule
